@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// MFTT_ASSERT is gated off while reset is asserted; MFTT_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MFTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`define MFTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/mftt_pkg.sv @@
// ----------------------------------------------------------------------------
// mftt_pkg: shared types and constants of the frame timer table
// Field widths, item and status codes, slot record and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package mftt_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int LIVE_W     = $clog2(MAX_TIMERS + 1);
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    localparam int KIND_W   = 2;
    localparam int FRAME_W  = 32;
    localparam int LOOP_W   = 8;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;

    localparam logic [HANDLE_W-1:0] HANDLE_NONE  = '0;
    localparam logic [HANDLE_W-1:0] HANDLE_FIRST = HANDLE_W'(1);
    localparam logic [HANDLE_W-1:0] HANDLE_MAX   = '1;

    // input item kinds; the fourth code is ignored
    typedef enum logic [KIND_W-1:0] {
        K_CREATE = 2'd0,
        K_CLEAR  = 2'd1,
        K_TICK   = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED   = 3'd0,
        ST_FULL      = 3'd1,
        ST_ZERO      = 3'd2,
        ST_CLEARED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EXPIRY    = 3'd5,
        ST_DONE      = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CREATE,
        S_CLR_SCAN,
        S_CLR_CHK,
        S_CLR_MOVE,
        S_TCK_SCAN,
        S_TCK_EVAL,
        S_TCK_MOVE
    } t_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_TOP
    } t_rd;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CREATE,
        WR_DEC,
        WR_RELOAD,
        WR_MOVE
    } t_wr;

    typedef enum logic [1:0] {
        H_NONE,
        H_NEXT,
        H_TARGET,
        H_SLOT
    } t_hsel;

    typedef struct packed {
        logic [HANDLE_W-1:0]      handle;
        logic [FRAME_W-1:0]       period;
        logic [FRAME_W-1:0]       remaining;
        logic signed [LOOP_W-1:0] loops;
    } t_slot;

    typedef struct packed {
        logic    load_item;
        t_rd     rd;
        t_wr     wr;
        logic    idx_clr;
        logic    idx_inc;
        logic    live_inc;
        logic    live_dec;
        logic    handle_adv;
        logic    emit;
        t_status emit_status;
        t_hsel   emit_hsel;
        logic    emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LIVE_W-1:0] live;
        logic              out_free;
        logic              full;
        logic              frames_zero;
        logic              target_zero;
        logic              idx_end;
        logic              idx_is_top;
        logic              hit;
        logic              expire;
        logic              retire;
    } t_dp_sts;

    localparam t_dp_cmd CMD_NOP = '{
        load_item:   1'b0,
        rd:          RD_NONE,
        wr:          WR_NONE,
        idx_clr:     1'b0,
        idx_inc:     1'b0,
        live_inc:    1'b0,
        live_dec:    1'b0,
        handle_adv:  1'b0,
        emit:        1'b0,
        emit_status: ST_DONE,
        emit_hsel:   H_NONE,
        emit_last:   1'b0
    };

endpackage

@@ hw/rtl/mftt_if.sv @@
// ----------------------------------------------------------------------------
// mftt_item_if / mftt_res_if: valid/ready channels of the timer table
// Request items in, result items out.
// ----------------------------------------------------------------------------
interface mftt_item_if import mftt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [FRAME_W-1:0]       frame_count;
    logic signed [LOOP_W-1:0] loop_total;
    logic [HANDLE_W-1:0]      target_handle;

    modport source (output valid, kind, frame_count, loop_total, target_handle,
                    input ready);
    modport sink   (input valid, kind, frame_count, loop_total, target_handle,
                    output ready);
endinterface

interface mftt_res_if import mftt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_handle;
    logic                last;

    modport source (output valid, status, result_handle, last, input ready);
    modport sink   (input valid, status, result_handle, last, output ready);
endinterface

@@ hw/rtl/mftt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mftt_ctrl: sequencer of the timer table
// Decodes each item and walks the slot table one entry at a time.
// ----------------------------------------------------------------------------
module mftt_ctrl import mftt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                o_cmd.idx_clr = 1'b1;
                case (i_sts.kind)
                    K_CREATE: n_state = S_CREATE;
                    K_CLEAR:  n_state = S_CLR_SCAN;
                    K_TICK:   n_state = S_TCK_SCAN;
                    default:  n_state = S_IDLE;
                endcase
            end

            S_CREATE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.emit_status = ST_FULL;
                    end else if (i_sts.frames_zero) begin
                        o_cmd.emit_status = ST_ZERO;
                    end else begin
                        o_cmd.emit_status = ST_CREATED;
                        o_cmd.emit_hsel   = H_NEXT;
                        o_cmd.wr          = WR_CREATE;
                        o_cmd.live_inc    = 1'b1;
                        o_cmd.handle_adv  = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end

            // clear: look for the lowest slot holding the handle
            S_CLR_SCAN: begin
                if (i_sts.target_zero || i_sts.idx_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_NOT_FOUND;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.rd = RD_IDX;
                    n_state  = S_CLR_CHK;
                end
            end

            S_CLR_CHK: begin
                if (!i_sts.hit) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CLR_SCAN;
                end else if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_CLEARED;
                    o_cmd.emit_hsel   = H_TARGET;
                    o_cmd.emit_last   = 1'b1;
                    if (i_sts.idx_is_top) begin
                        o_cmd.live_dec = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.rd = RD_TOP;
                        n_state  = S_CLR_MOVE;
                    end
                end
            end

            S_CLR_MOVE: begin
                o_cmd.wr       = WR_MOVE;
                o_cmd.live_dec = 1'b1;
                n_state        = S_IDLE;
            end

            // tick: count down each live slot, emit expiries
            S_TCK_SCAN: begin
                if (i_sts.idx_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_DONE;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.rd = RD_IDX;
                    n_state  = S_TCK_EVAL;
                end
            end

            S_TCK_EVAL: begin
                if (!i_sts.expire) begin
                    o_cmd.wr      = WR_DEC;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_TCK_SCAN;
                end else if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_EXPIRY;
                    o_cmd.emit_hsel   = H_SLOT;
                    if (!i_sts.retire) begin
                        o_cmd.wr      = WR_RELOAD;
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_TCK_SCAN;
                    end else if (i_sts.idx_is_top) begin
                        o_cmd.live_dec = 1'b1;
                        n_state        = S_TCK_SCAN;
                    end else begin
                        o_cmd.rd = RD_TOP;
                        n_state  = S_TCK_MOVE;
                    end
                end
            end

            // moved entry lands in this slot and is visited next
            S_TCK_MOVE: begin
                o_cmd.wr       = WR_MOVE;
                o_cmd.live_dec = 1'b1;
                n_state        = S_TCK_SCAN;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mftt_dpath.sv @@
// ----------------------------------------------------------------------------
// mftt_dpath: slot memory, counters and result register
// Holds the packed timer table and executes the sequencer's commands.
// ----------------------------------------------------------------------------
module mftt_dpath import mftt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [FRAME_W-1:0]       i_frame_count,
    input  logic signed [LOOP_W-1:0] i_loop_total,
    input  logic [HANDLE_W-1:0]      i_target_handle,
    input  logic                     i_res_ready,
    output logic                     o_res_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [HANDLE_W-1:0]      o_result_handle,
    output logic                     o_last
);

    // latched item
    logic [KIND_W-1:0]        r_kind;
    logic [FRAME_W-1:0]       r_frames;
    logic signed [LOOP_W-1:0] r_loops;
    logic [HANDLE_W-1:0]      r_target;

    logic [LIVE_W-1:0]   r_live;
    logic [LIVE_W-1:0]   r_idx;
    logic [HANDLE_W-1:0] r_next_handle;

    t_slot r_mem [MAX_TIMERS];
    t_slot r_rd;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_out_last;

    logic [LIVE_W-1:0] live_m1;
    logic [IDX_W-1:0]  top_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    t_slot             wr_data;
    logic              loops_pos;
    logic [HANDLE_W-1:0] emit_handle;

    assign live_m1   = LIVE_W'(r_live - 1'b1);
    assign top_addr  = live_m1[IDX_W-1:0];
    assign loops_pos = !r_rd.loops[LOOP_W-1] && (r_rd.loops != '0);

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind   <= i_kind;
            r_frames <= i_frame_count;
            r_loops  <= i_loop_total;
            r_target <= i_target_handle;
        end
    end

    // live count, walk index, handle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= '0;
            r_idx         <= '0;
            r_next_handle <= HANDLE_FIRST;
        end else begin
            if (i_cmd.live_inc) begin
                r_live <= LIVE_W'(r_live + 1'b1);
            end else if (i_cmd.live_dec) begin
                r_live <= live_m1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= LIVE_W'(r_idx + 1'b1);
            end
            if (i_cmd.handle_adv) begin
                r_next_handle <= (r_next_handle == HANDLE_MAX) ? HANDLE_FIRST
                                 : HANDLE_W'(r_next_handle + 1'b1);
            end
        end
    end

    // slot write address and data
    always_comb begin
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = r_rd;
        case (i_cmd.wr)
            WR_CREATE: begin
                wr_addr           = r_live[IDX_W-1:0];
                wr_data.handle    = r_next_handle;
                wr_data.period    = r_frames;
                wr_data.remaining = r_frames;
                wr_data.loops     = r_loops;
            end
            WR_DEC: begin
                wr_data.remaining = (r_rd.remaining != '0)
                                    ? FRAME_W'(r_rd.remaining - 1'b1) : r_rd.remaining;
            end
            WR_RELOAD: begin
                wr_data.remaining = r_rd.period;
                wr_data.loops     = loops_pos ? LOOP_W'(r_rd.loops - 1'b1) : r_rd.loops;
            end
            default: begin
                wr_data = r_rd;
            end
        endcase
    end

    assign rd_addr = (i_cmd.rd == RD_TOP) ? top_addr : r_idx[IDX_W-1:0];

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr != WR_NONE) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd != RD_NONE) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // handle shown on the result
    always_comb begin
        case (i_cmd.emit_hsel)
            H_NEXT:   emit_handle = r_next_handle;
            H_TARGET: emit_handle = r_target;
            H_SLOT:   emit_handle = r_rd.handle;
            default:  emit_handle = HANDLE_NONE;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_handle <= emit_handle;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_handle = r_out_handle;
    assign o_last          = r_out_last;

    // status to the sequencer
    always_comb begin
        o_sts.kind        = r_kind;
        o_sts.live        = r_live;
        o_sts.out_free    = !r_out_valid || i_res_ready;
        o_sts.full        = (r_live >= LIVE_W'(MAX_TIMERS));
        o_sts.frames_zero = (r_frames == '0);
        o_sts.target_zero = (r_target == HANDLE_NONE);
        o_sts.idx_end     = (r_idx >= r_live);
        o_sts.idx_is_top  = (r_idx == live_m1);
        o_sts.hit         = (r_rd.handle == r_target);
        o_sts.expire      = (r_rd.remaining <= FRAME_W'(1));
        o_sts.retire      = (r_rd.loops == '0) || (r_rd.loops == LOOP_W'(1));
    end

endmodule

@@ hw/rtl/multi_frame_timer_table.sv @@
// ----------------------------------------------------------------------------
// multi_frame_timer_table: packed table of reloading countdown timers
// Create, clear and tick requests in; created/full/zero/cleared/not-found/expiry/done results out.
// ----------------------------------------------------------------------------
// Usage:
//   i_item takes one request item at a time (create, clear or frame tick);
//   ready is high only while the sequencer is idle. o_res gives result
//   items through a one-entry output register; last marks the final result
//   of a request. The next request is taken while that result still waits.
//   A create answers after decode. A clear reads and checks each slot up
//   to the match and moves the last entry into the freed slot unless the
//   match is that entry. A tick reads and evaluates each live slot, pulls
//   the last entry into each retired slot that is not the last, and then
//   gives the done result. The walk goes over the slot memory one entry
//   at a time, with registered read.
//   A stalled receiver holds the walk at the next result until the output
//   register frees; nothing is lost. Reset empties the table and sets the
//   handle counter to one; slot contents are not cleared, only live ones
//   are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_frame_timer_table import mftt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mftt_item_if.sink   i_item,
    mftt_res_if.source  o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mftt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mftt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_item.kind),
        .i_frame_count   (i_item.frame_count),
        .i_loop_total    (i_item.loop_total),
        .i_target_handle (i_item.target_handle),
        .i_res_ready     (o_res.ready),
        .o_res_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_result_handle (o_res.result_handle),
        .o_last          (o_res.last)
    );

    // never overwrite a result that has not been taken
    `MFTT_ASSERT(a_emit_free, i_clk, i_rst_n, cmd.emit |-> sts.out_free, "result overwritten")
    // table bounds
    `MFTT_ASSERT(a_no_overfill, i_clk, i_rst_n, cmd.live_inc |-> !sts.full, "create into full table")
    `MFTT_ASSERT(a_no_underflow, i_clk, i_rst_n, cmd.live_dec |-> (sts.live != '0),
        "remove from empty table")
    // a request is only taken when no result of it can be pending behind it
    `MFTT_ASSERT(a_accept_idle, i_clk, i_rst_n,
        (i_item.valid && i_item.ready) |=> (!cmd.emit && (cmd.wr == WR_NONE)),
        "work issued during decode")

endmodule
